FILE: sv/fsp_pkg.sv
package fsp_pkg;

    localparam int unsigned PAYLOAD_LEN = 56;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned OUT_DATA_W  = 264;

    // Field boundaries inside the payload
    localparam logic [POS_W-1:0] MAGIC_START   = 6'd16;
    localparam logic [POS_W-1:0] VERSION_POS   = 6'd20;
    localparam logic [POS_W-1:0] FLAG_POS      = 6'd21;
    localparam logic [POS_W-1:0] FRAME_START   = 6'd24;
    localparam logic [POS_W-1:0] SOURCE_START  = 6'd32;
    localparam logic [POS_W-1:0] ENCODER_START = 6'd40;
    localparam logic [POS_W-1:0] CAPTURE_START = 6'd48;
    localparam logic [POS_W-1:0] LEN_POS       = 6'd56;

    // UUID, byte 0 in the lowest lane
    localparam logic [15:0][7:0] UUID_BYTES = {
        8'h01, 8'h44, 8'h49, 8'h45, 8'h4d, 8'h41, 8'h52, 8'h46,
        8'h41, 8'h52, 8'h45, 8'h4d, 8'h41, 8'h43, 8'h45, 8'h52
    };

    // "RCFS", byte 0 in the lowest lane
    localparam logic [3:0][7:0] MAGIC_BYTES = {8'h53, 8'h46, 8'h43, 8'h52};

    localparam logic [7:0] VERSION_BYTE = 8'h01;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_SHORT   = 3'd1,
        STATUS_UUID    = 3'd2,
        STATUS_MAGIC   = 3'd3,
        STATUS_VERSION = 3'd4
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] capture_millis;
        logic [VALUE_W-1:0] encoder_stamp;
        logic [VALUE_W-1:0] source_stamp;
        logic [VALUE_W-1:0] frame_number;
        logic               exact_match;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

endpackage

FILE: sv/fsp_in_reg.sv
module fsp_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] payload_byte
    input  logic               s_axis_tlast,
    input  logic               advance,
    output fsp_pkg::in_item_t  item
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign s_axis_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

    assign item.valid     = valid_reg;
    assign item.data_byte = byte_reg;
    assign item.last      = last_reg;

endmodule

FILE: sv/fsp_parse_core.sv
module fsp_parse_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output fsp_pkg::result_t  result
);

    logic [fsp_pkg::POS_W-1:0]   pos_reg, pos_next, pos_upd;
    logic                        uuid_bad_reg, uuid_bad_next, uuid_bad_upd;
    logic                        magic_bad_reg, magic_bad_next, magic_bad_upd;
    logic                        version_bad_reg, version_bad_next, version_bad_upd;
    logic                        match_reg, match_next, match_upd;
    logic [fsp_pkg::VALUE_W-1:0] frame_reg, frame_next, frame_upd;
    logic [fsp_pkg::VALUE_W-1:0] source_reg, source_next, source_upd;
    logic [fsp_pkg::VALUE_W-1:0] encoder_reg, encoder_next, encoder_upd;
    logic [fsp_pkg::VALUE_W-1:0] capture_reg, capture_next, capture_upd;
    logic [fsp_pkg::VALUE_W-1:0] shifted_byte;
    fsp_pkg::status_t            status;

    // Apply the current byte to the running state
    always_comb
    begin
        pos_upd         = pos_reg;
        uuid_bad_upd    = uuid_bad_reg;
        magic_bad_upd   = magic_bad_reg;
        version_bad_upd = version_bad_reg;
        match_upd       = match_reg;
        frame_upd       = frame_reg;
        source_upd      = source_reg;
        encoder_upd     = encoder_reg;
        capture_upd     = capture_reg;
        shifted_byte    = {{(fsp_pkg::VALUE_W-8){1'b0}}, data_byte};

        if (pos_reg < fsp_pkg::LEN_POS)
        begin
            pos_upd = pos_reg + 6'd1;
            if (pos_reg < fsp_pkg::MAGIC_START)
            begin
                if (data_byte != fsp_pkg::UUID_BYTES[pos_reg[3:0]])
                    uuid_bad_upd = 1'b1;
            end
            else if (pos_reg < fsp_pkg::VERSION_POS)
            begin
                // magic starts on a multiple of four
                if (data_byte != fsp_pkg::MAGIC_BYTES[pos_reg[1:0]])
                    magic_bad_upd = 1'b1;
            end
            else if (pos_reg == fsp_pkg::VERSION_POS)
            begin
                if (data_byte != fsp_pkg::VERSION_BYTE)
                    version_bad_upd = 1'b1;
            end
            else if (pos_reg == fsp_pkg::FLAG_POS)
            begin
                match_upd = (data_byte != 8'd0);
            end
            else if (pos_reg < fsp_pkg::FRAME_START)
            begin
                // reserved bytes
            end
            else if (pos_reg < fsp_pkg::SOURCE_START)
            begin
                frame_upd = {frame_reg[fsp_pkg::VALUE_W-9:0], 8'd0} | shifted_byte;
            end
            else if (pos_reg < fsp_pkg::ENCODER_START)
            begin
                source_upd = {source_reg[fsp_pkg::VALUE_W-9:0], 8'd0} | shifted_byte;
            end
            else if (pos_reg < fsp_pkg::CAPTURE_START)
            begin
                encoder_upd = {encoder_reg[fsp_pkg::VALUE_W-9:0], 8'd0} | shifted_byte;
            end
            else
            begin
                capture_upd = {capture_reg[fsp_pkg::VALUE_W-9:0], 8'd0} | shifted_byte;
            end
        end
    end

    // Status priority: length first, then uuid, magic, version
    always_comb
    begin
        if (pos_upd < fsp_pkg::LEN_POS)
            status = fsp_pkg::STATUS_SHORT;
        else if (uuid_bad_upd)
            status = fsp_pkg::STATUS_UUID;
        else if (magic_bad_upd)
            status = fsp_pkg::STATUS_MAGIC;
        else if (version_bad_upd)
            status = fsp_pkg::STATUS_VERSION;
        else
            status = fsp_pkg::STATUS_OK;

        result.status = status;
        if (status == fsp_pkg::STATUS_OK)
        begin
            result.exact_match    = match_upd;
            result.frame_number   = frame_upd;
            result.source_stamp   = source_upd;
            result.encoder_stamp  = encoder_upd;
            result.capture_millis = capture_upd;
        end
        else
        begin
            result.exact_match    = 1'b0;
            result.frame_number   = '0;
            result.source_stamp   = '0;
            result.encoder_stamp  = '0;
            result.capture_millis = '0;
        end
    end

    // Last byte returns the parser to its reset state
    always_comb
    begin
        pos_next         = pos_reg;
        uuid_bad_next    = uuid_bad_reg;
        magic_bad_next   = magic_bad_reg;
        version_bad_next = version_bad_reg;
        match_next       = match_reg;
        frame_next       = frame_reg;
        source_next      = source_reg;
        encoder_next     = encoder_reg;
        capture_next     = capture_reg;
        if (take)
        begin
            if (last_byte)
            begin
                pos_next         = '0;
                uuid_bad_next    = 1'b0;
                magic_bad_next   = 1'b0;
                version_bad_next = 1'b0;
                match_next       = 1'b0;
                frame_next       = '0;
                source_next      = '0;
                encoder_next     = '0;
                capture_next     = '0;
            end
            else
            begin
                pos_next         = pos_upd;
                uuid_bad_next    = uuid_bad_upd;
                magic_bad_next   = magic_bad_upd;
                version_bad_next = version_bad_upd;
                match_next       = match_upd;
                frame_next       = frame_upd;
                source_next      = source_upd;
                encoder_next     = encoder_upd;
                capture_next     = capture_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            uuid_bad_reg    <= 1'b0;
            magic_bad_reg   <= 1'b0;
            version_bad_reg <= 1'b0;
            match_reg       <= 1'b0;
            frame_reg       <= '0;
            source_reg      <= '0;
            encoder_reg     <= '0;
            capture_reg     <= '0;
        end
        else
        begin
            pos_reg         <= pos_next;
            uuid_bad_reg    <= uuid_bad_next;
            magic_bad_reg   <= magic_bad_next;
            version_bad_reg <= version_bad_next;
            match_reg       <= match_next;
            frame_reg       <= frame_next;
            source_reg      <= source_next;
            encoder_reg     <= encoder_next;
            capture_reg     <= capture_next;
        end
    end

endmodule

FILE: sv/frame_sync_payload_parser_unit.sv
// Frame-sync SEI payload parser. Feed the user-data payload one byte per
// transaction on the slave stream, tlast on the final byte. Bytes 0..15
// are checked against the fixed UUID, 16..19 against the magic "RCFS",
// byte 20 against version 1; byte 21 gives exact_match, 22..23 are
// reserved, 24..55 load four big-endian 64-bit fields. Bytes past 55 are
// dropped but tlast still closes the payload. Each tlast byte produces one
// result transaction on the master stream; every other byte produces none.
// Status codes: 0 ok, 1 too short (fewer than 56 bytes), 2 uuid mismatch,
// 3 magic mismatch, 4 version mismatch, with shortness taking priority,
// then uuid, magic, version. All value fields read zero unless status is
// ok. Throughput is one byte per clock unless a final byte waits on a held
// result: the input register feeds a single compare-and-shift step into the
// parse state, and the result register is loaded in that same step. The
// final byte goes from the input register to the result register, which
// drives m_axis_tvalid. A waiting result only blocks the input when the
// next byte to be processed is itself a final byte; ordinary bytes keep
// flowing. After reset the parser waits for byte 0 of a new payload.
module frame_sync_payload_parser_unit (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] payload_byte
    input  logic         s_axis_tlast,   // final_byte

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [3] exact_match, [67:4] frame_number,
    // [131:68] source_stamp, [195:132] encoder_stamp,
    // [259:196] capture_millis, [263:260] zero
    output logic [fsp_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    fsp_pkg::in_item_t item;
    fsp_pkg::result_t  core_result;
    logic              advance;
    logic              load_out;

    logic              out_valid_reg, out_valid_next;
    fsp_pkg::result_t  out_data_reg;

    // A final byte needs the result register free (or draining this cycle)
    assign advance  = item.valid && (!item.last || !out_valid_reg || m_axis_tready);
    assign load_out = advance && item.last;

    fsp_in_reg u_in_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item          (item)
    );

    fsp_parse_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (advance),
        .data_byte (item.data_byte),
        .last_byte (item.last),
        .result    (core_result)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_data_reg};

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

// Payload-level testbench for the frame-sync SEI parser. Payloads go in one
// byte per transaction. The predictor below parses every accepted byte and
// queues one expected result per tlast. The result checker pops that queue
// in order.
module tb_top;

    localparam int CLK_HALF         = 5;
    localparam int RESET_CYCLES     = 10;
    localparam int MAX_GAP          = 18;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 3000;   // cycles with no transaction on either side
    localparam int DRAIN_CYCLES     = 12;     // margin for stray results after the queue empties
    localparam int RANDOM_BYTES     = 60;

    logic                           clk           = 1'b0;
    logic                           rst_n         = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata  = 8'h00;   // [7:0] payload_byte
    logic                           s_axis_tlast  = 1'b0;    // final_byte
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [fsp_pkg::OUT_DATA_W-1:0] m_axis_tdata;  // result_t in [259:0], zero above

    // Idling controls, flipped by the test tasks
    bit sender_gaps_on = 1'b1;
    bit sink_stalls_on = 1'b1;
    bit long_hold_req  = 1'b0;

    // Parser state mirrored by the predictor
    logic [fsp_pkg::POS_W-1:0]   parse_pos   = '0;
    logic                        uuid_err    = 1'b0;
    logic                        magic_err   = 1'b0;
    logic                        version_err = 1'b0;
    logic                        flag_seen   = 1'b0;
    logic [fsp_pkg::VALUE_W-1:0] frame_acc   = '0;
    logic [fsp_pkg::VALUE_W-1:0] source_acc  = '0;
    logic [fsp_pkg::VALUE_W-1:0] encoder_acc = '0;
    logic [fsp_pkg::VALUE_W-1:0] capture_acc = '0;

    fsp_pkg::result_t pending_results[$];
    logic [7:0]       payload[$];

    int mismatches      = 0;
    int bytes_sent      = 0;
    int payloads_sent   = 0;
    int results_checked = 0;
    int long_holds_done = 0;
    int status_count[5] = '{default: 0};

    frame_sync_payload_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: one accepted byte in, zero or one expected result queued.
    // Position saturates at the payload length, so trailing bytes only
    // matter through tlast.
    // ------------------------------------------------------------------
    function automatic void predict_byte(input logic [7:0] value, input logic is_last);
        fsp_pkg::result_t r;
        if (parse_pos < fsp_pkg::LEN_POS)
        begin
            if (parse_pos < fsp_pkg::MAGIC_START)
            begin
                if (value != fsp_pkg::UUID_BYTES[parse_pos[3:0]])
                    uuid_err = 1'b1;
            end
            else if (parse_pos < fsp_pkg::VERSION_POS)
            begin
                // magic starts on a multiple of four, so the low bits index it
                if (value != fsp_pkg::MAGIC_BYTES[parse_pos[1:0]])
                    magic_err = 1'b1;
            end
            else if (parse_pos == fsp_pkg::VERSION_POS)
            begin
                if (value != fsp_pkg::VERSION_BYTE)
                    version_err = 1'b1;
            end
            else if (parse_pos == fsp_pkg::FLAG_POS)
            begin
                flag_seen = (value != 8'h00);
            end
            else if (parse_pos < fsp_pkg::FRAME_START)
            begin
                // reserved bytes, not checked
            end
            else if (parse_pos < fsp_pkg::SOURCE_START)
                frame_acc = {frame_acc[fsp_pkg::VALUE_W-9:0], value};
            else if (parse_pos < fsp_pkg::ENCODER_START)
                source_acc = {source_acc[fsp_pkg::VALUE_W-9:0], value};
            else if (parse_pos < fsp_pkg::CAPTURE_START)
                encoder_acc = {encoder_acc[fsp_pkg::VALUE_W-9:0], value};
            else
                capture_acc = {capture_acc[fsp_pkg::VALUE_W-9:0], value};
            parse_pos = parse_pos + 6'd1;
        end

        if (is_last)
        begin
            r = '0;
            // shortness outranks any mismatch; value fields only on ok
            if (parse_pos < fsp_pkg::LEN_POS)
                r.status = fsp_pkg::STATUS_SHORT;
            else if (uuid_err)
                r.status = fsp_pkg::STATUS_UUID;
            else if (magic_err)
                r.status = fsp_pkg::STATUS_MAGIC;
            else if (version_err)
                r.status = fsp_pkg::STATUS_VERSION;
            else
            begin
                r.status         = fsp_pkg::STATUS_OK;
                r.exact_match    = flag_seen;
                r.frame_number   = frame_acc;
                r.source_stamp   = source_acc;
                r.encoder_stamp  = encoder_acc;
                r.capture_millis = capture_acc;
            end
            pending_results = {pending_results, r};
            status_count[r.status]++;

            // back to the start of the next payload
            parse_pos   = '0;
            uuid_err    = 1'b0;
            magic_err   = 1'b0;
            version_err = 1'b0;
            flag_seen   = 1'b0;
            frame_acc   = '0;
            source_acc  = '0;
            encoder_acc = '0;
            capture_acc = '0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Payload builders. All but pick_value write the shared payload queue.
    // ------------------------------------------------------------------
    function automatic void append_byte(input logic [7:0] value);
        payload = {payload, value};
    endfunction

    function automatic logic [fsp_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;   // only the most significant bit set
            3:       return 64'h7fff_ffff_ffff_ffff;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic void build_valid_payload(input logic [7:0] flag,
                                                input logic [fsp_pkg::VALUE_W-1:0] frame_no,
                                                input logic [fsp_pkg::VALUE_W-1:0] src_ts,
                                                input logic [fsp_pkg::VALUE_W-1:0] enc_ts,
                                                input logic [fsp_pkg::VALUE_W-1:0] cap_ms);
        logic [4*fsp_pkg::VALUE_W-1:0] values;
        values = {frame_no, src_ts, enc_ts, cap_ms};
        payload.delete();
        for (int i = 0; i < 16; i++)
            append_byte(fsp_pkg::UUID_BYTES[i]);
        for (int i = 0; i < 4; i++)
            append_byte(fsp_pkg::MAGIC_BYTES[i]);
        append_byte(fsp_pkg::VERSION_BYTE);
        append_byte(flag);
        append_byte(8'($urandom_range(0, 255)));
        append_byte(8'($urandom_range(0, 255)));
        // big-endian: most significant byte of frame_no goes first
        for (int k = 4 * fsp_pkg::VALUE_W / 8 - 1; k >= 0; k--)
            append_byte(values[8*k +: 8]);
    endfunction

    function automatic void append_noise(input int count);
        for (int i = 0; i < count; i++)
            append_byte(8'($urandom_range(0, 255)));
    endfunction

    // Mostly well-formed payloads with random content; the rest broken
    // headers, truncations, overlong tails and plain noise.
    function automatic void build_random_payload();
        int kind;
        int cut;
        kind = $urandom_range(0, 19);
        build_valid_payload(8'($urandom_range(0, 1) ? $urandom_range(0, 255) : 0),
                            pick_value(), pick_value(), pick_value(), pick_value());
        if (kind < 10)
        begin
            if ($urandom_range(0, 2) == 0)
                append_noise($urandom_range(1, 24));
        end
        else if (kind < 13)
        begin
            // corrupt one to three header bytes
            repeat ($urandom_range(1, 3))
            begin
                cut = $urandom_range(0, int'(fsp_pkg::FLAG_POS) - 1);
                payload[cut] = payload[cut] ^ 8'($urandom_range(1, 255));
            end
        end
        else if (kind < 16)
        begin
            cut = $urandom_range(1, fsp_pkg::PAYLOAD_LEN - 1);
            while (payload.size() > cut)
                void'(payload.pop_back());
        end
        else if (kind < 18)
        begin
            payload.delete();
            append_noise($urandom_range(1, 72));
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: one byte per call, optional gap before it, returns at the
    // accepting edge. Valid stays high across back-to-back bytes.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        int gap;
        gap = 0;
        if (sender_gaps_on && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, MAX_GAP);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        predict_byte(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_payload();
        foreach (payload[i])
            send_byte(payload[i], i == payload.size() - 1);
        payloads_sent++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_short_payloads();
        payload.delete();
        append_byte(8'h00);
        send_payload();
        payload.delete();
        append_byte(8'hff);
        send_payload();
        // one byte short of a full payload
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        void'(payload.pop_back());
        send_payload();
        // truncated and also a bad UUID: shortness wins
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        payload[0] = 8'h00;
        while (payload.size() > 30)
            void'(payload.pop_back());
        send_payload();
    endtask

    task automatic test_valid_payloads();
        build_valid_payload(8'hff, '1, '1, '1, '1);
        send_payload();
        build_valid_payload(8'h01, 64'h0123_4567_89ab_cdef, 64'h8000_0000_0000_0000,
                            64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        send_payload();
    endtask

    task automatic test_mismatch_priority();
        // uuid and magic both bad
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        payload[15] = payload[15] ^ 8'h01;
        payload[16] = payload[16] ^ 8'h80;
        send_payload();
        // magic and version both bad
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        payload[19] = payload[19] ^ 8'h20;
        payload[fsp_pkg::VERSION_POS] = 8'h00;
        send_payload();
        // version alone
        build_valid_payload(8'hff, pick_value(), pick_value(), pick_value(), pick_value());
        payload[fsp_pkg::VERSION_POS] = 8'hff;
        send_payload();
    endtask

    task automatic test_overlength();
        // long enough to wrap a 6-bit counter if it failed to saturate
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        append_noise(10);
        send_payload();
        build_valid_payload(8'h01, pick_value(), pick_value(), pick_value(), pick_value());
        payload[fsp_pkg::VERSION_POS] = 8'h02;
        append_noise(5);
        send_payload();
    endtask

    // Output held off for a long stretch while one-byte payloads keep
    // coming, so a waiting result fills the result register and the input stalls.
    task automatic test_backpressure();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        long_hold_req  = 1'b1;
        repeat (20)
        begin
            payload.delete();
            append_byte(8'($urandom_range(0, 255)));
            send_payload();
        end
    endtask

    task automatic test_random_traffic();
        int start_bytes;
        start_bytes = bytes_sent;
        while (bytes_sent - start_bytes < RANDOM_BYTES)
        begin
            // idling switched per payload, giving stretches with and without it
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            build_random_payload();
            send_payload();
        end
    endtask

    task automatic test_streaming_no_idle();
        sender_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        repeat (2)
        begin
            build_random_payload();
            send_payload();
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: ready pattern, long hold on request.
    // ------------------------------------------------------------------
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_holds_done++;
                m_axis_tready <= 1'b1;
            end
            else if (sink_stalls_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic void compare_field(input string field,
                                          input logic [fsp_pkg::VALUE_W-1:0] want,
                                          input logic [fsp_pkg::VALUE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Result checker: every result transaction against the oldest expectation
    initial
    begin
        fsp_pkg::result_t got;
        fsp_pkg::result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got = fsp_pkg::result_t'(m_axis_tdata[$bits(fsp_pkg::result_t)-1:0]);
                if (pending_results.size() == 0)
                begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("exact_match", want.exact_match, got.exact_match);
                    compare_field("frame_number", want.frame_number, got.frame_number);
                    compare_field("source_stamp", want.source_stamp, got.source_stamp);
                    compare_field("encoder_stamp", want.encoder_stamp, got.encoder_stamp);
                    compare_field("capture_millis", want.capture_millis, got.capture_millis);
                    results_checked++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either side ends the run
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t ns: timeout, no transaction for %0d cycles, %0d results outstanding",
                 $time, IDLE_LIMIT, pending_results.size());
        $display("[frame_sync_payload_parser_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_payloads();
        test_valid_payloads();
        test_mismatch_priority();
        test_overlength();
        test_backpressure();
        test_random_traffic();
        test_streaming_no_idle();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d payloads in %0d bytes, checked %0d results, %0d long output hold(s)",
                 payloads_sent, bytes_sent, results_checked, long_holds_done);
        $display("Results by status: ok %0d, short %0d, uuid %0d, magic %0d, version %0d",
                 status_count[fsp_pkg::STATUS_OK], status_count[fsp_pkg::STATUS_SHORT],
                 status_count[fsp_pkg::STATUS_UUID], status_count[fsp_pkg::STATUS_MAGIC],
                 status_count[fsp_pkg::STATUS_VERSION]);
        if (mismatches == 0)
            $display("[frame_sync_payload_parser_unit] OK");
        else
            $display("[frame_sync_payload_parser_unit] ERROR");
        $finish;
    end

endmodule
